[rtl/core/rrg_pkg.sv]
package rrg_pkg;

  // defaults for the top-level parameters
  localparam int DEF_WINDOW_DEPTH = 64;
  localparam int DEF_MAX_SHIFT    = 20;

  // field and register widths
  localparam int RTT_W    = 16;
  localparam int WAIT_W   = 20;
  localparam int BASE_W   = 16;
  localparam int MAXDIV_W = 7;
  localparam int FACTOR_W = 12;
  localparam int MINDEG_W = 10;
  localparam int DIV_W    = 13;
  localparam int STREAK_W = 5;
  localparam int DEG_W    = 20;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BASE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CAP      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAXDIV   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_EXPECTED = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_LOW      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_MINDEG   = 3'd6;

  // constants
  localparam logic [DIV_W-1:0]    DIV_ONE        = 13'd64;
  localparam logic [DEG_W-1:0]    DEGRADED_LIMIT = 20'd1000000;
  localparam logic [STREAK_W-1:0] STREAK_LIMIT   = 5'd31;
  localparam logic [FACTOR_W-1:0] FACTOR_ONE     = 12'd256;
  localparam logic [FACTOR_W-1:0] HIGH_DEFAULT   = 12'd461;
  localparam logic [FACTOR_W-1:0] LOW_DEFAULT    = 12'd333;
  localparam logic [MAXDIV_W-1:0] MAXDIV_LIMIT   = 7'd64;

  // window chain control
  typedef struct packed {
    logic shift;  // insert new sample at the head
    logic load;   // copy samples into the rotating ring, clear counts
    logic count;  // compare and rotate
    logic scan;   // move the median token along
  } chain_ctl_t;

  // policy control
  typedef struct packed {
    logic accept;   // report taken: session minimum update
    logic mul;      // form threshold products
    logic decide;   // commit backoff and governor state
    logic seed;     // reseed session minimum from expected RTT
  } policy_ctl_t;

endpackage

[rtl/core/rrg_cell.sv]
module rrg_cell #(
  parameter int CNT_W = 7
) (
  input  logic                       clk,
  input  rrg_pkg::chain_ctl_t        ctl,
  input  logic                       valid,
  input  logic [CNT_W-1:0]           k,
  input  logic [rrg_pkg::RTT_W-1:0]  s_in,
  input  logic [rrg_pkg::RTT_W-1:0]  rot_in,
  input  logic                       rot_v_in,
  input  logic [rrg_pkg::RTT_W-1:0]  res_in,
  output logic [rrg_pkg::RTT_W-1:0]  s_out,
  output logic [rrg_pkg::RTT_W-1:0]  rot_out,
  output logic                       rot_v_out,
  output logic [rrg_pkg::RTT_W-1:0]  res_out
);
  import rrg_pkg::*;

  logic [RTT_W-1:0] sample;
  logic [RTT_W-1:0] rot;
  logic             rot_v;
  logic [CNT_W-1:0] lt_cnt;
  logic [CNT_W-1:0] le_cnt;
  logic [RTT_W-1:0] res;
  logic             match;

  // this sample is the upper median when lt <= k < le
  assign match = valid && (lt_cnt <= k) && (k < le_cnt);

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      sample <= s_in;
    end
    if (ctl.load) begin
      rot    <= sample;
      rot_v  <= valid;
      lt_cnt <= '0;
      le_cnt <= '0;
    end else if (ctl.count) begin
      if (rot_v && valid) begin
        if (rot < sample) begin
          lt_cnt <= lt_cnt + 1'b1;
        end
        if (rot <= sample) begin
          le_cnt <= le_cnt + 1'b1;
        end
      end
      rot   <= rot_in;
      rot_v <= rot_v_in;
    end
    if (ctl.scan) begin
      res <= match ? sample : res_in;
    end
  end

  assign s_out     = sample;
  assign rot_out   = rot;
  assign rot_v_out = rot_v;
  assign res_out   = res;

endmodule

[rtl/core/rrg_chain.sv]
module rrg_chain #(
  parameter int WINDOW_DEPTH = rrg_pkg::DEF_WINDOW_DEPTH,
  parameter int CNT_W        = $clog2(WINDOW_DEPTH + 1)
) (
  input  logic                       clk,
  input  rrg_pkg::chain_ctl_t        ctl,
  input  logic [CNT_W-1:0]           fill,
  input  logic [rrg_pkg::RTT_W-1:0]  new_rtt,
  output logic [rrg_pkg::RTT_W-1:0]  median
);
  import rrg_pkg::*;

  logic [RTT_W-1:0] s_q   [WINDOW_DEPTH];
  logic [RTT_W-1:0] rot_q [WINDOW_DEPTH];
  logic             rv_q  [WINDOW_DEPTH];
  logic [RTT_W-1:0] res_q [WINDOW_DEPTH];
  logic [CNT_W-1:0] k;

  assign k = fill >> 1;

  for (genvar i = 0; i < WINDOW_DEPTH; i++) begin : g_cell
    localparam int PREV = (i == 0) ? WINDOW_DEPTH - 1 : i - 1;
    logic [RTT_W-1:0] s_in;
    logic [RTT_W-1:0] res_in;
    logic             valid;

    assign valid = CNT_W'(i) < fill;
    if (i == 0) begin : g_head
      assign s_in   = new_rtt;
      assign res_in = '0;
    end else begin : g_body
      assign s_in   = s_q[i-1];
      assign res_in = res_q[i-1];
    end

    rrg_cell #(.CNT_W(CNT_W)) u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .valid     (valid),
      .k         (k),
      .s_in      (s_in),
      .rot_in    (rot_q[PREV]),
      .rot_v_in  (rv_q[PREV]),
      .res_in    (res_in),
      .s_out     (s_q[i]),
      .rot_out   (rot_q[i]),
      .rot_v_out (rv_q[i]),
      .res_out   (res_q[i])
    );
  end

  assign median = res_q[WINDOW_DEPTH-1];

endmodule

[rtl/core/rrg_policy.sv]
module rrg_policy #(
  parameter int MAX_SHIFT = rrg_pkg::DEF_MAX_SHIFT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  rrg_pkg::policy_ctl_t          ctl,
  input  logic [rrg_pkg::RTT_W-1:0]     rtt,
  input  logic                          limited,
  input  logic [rrg_pkg::WAIT_W-1:0]    retry,
  input  logic [rrg_pkg::RTT_W-1:0]     median,
  input  logic [rrg_pkg::BASE_W-1:0]    base,
  input  logic [rrg_pkg::WAIT_W-1:0]    cap,
  input  logic [rrg_pkg::MAXDIV_W-1:0]  maxdiv,
  input  logic [rrg_pkg::RTT_W-1:0]     expected,
  input  logic [rrg_pkg::FACTOR_W-1:0]  high_f,
  input  logic [rrg_pkg::FACTOR_W-1:0]  low_f,
  input  logic [rrg_pkg::MINDEG_W-1:0]  mindeg,
  output logic [rrg_pkg::WAIT_W-1:0]    wait_next,
  output logic [rrg_pkg::RTT_W-1:0]     session_min,
  output logic [rrg_pkg::DIV_W-1:0]     divisor_next,
  output logic                          bflag_next,
  output logic                          sflag_next
);
  import rrg_pkg::*;

  localparam int SW = BASE_W + MAX_SHIFT;
  localparam int CW = (SW > WAIT_W) ? SW : WAIT_W;
  localparam logic [STREAK_W-1:0] SHIFT_LIM = STREAK_W'(MAX_SHIFT);

  logic [STREAK_W-1:0] streak;
  logic [DEG_W-1:0]    degraded;
  logic [DIV_W-1:0]    divisor;
  logic                sflag;
  logic [27:0]         p_hi;
  logic [29:0]         p_lo;

  logic [STREAK_W-1:0] streak_next;
  logic [DEG_W-1:0]    degraded_next;

  logic [BASE_W-1:0]   base_eff;
  logic [WAIT_W-1:0]   cap_eff;
  logic [STREAK_W-1:0] shift;
  logic [SW-1:0]       bo;
  logic [CW-1:0]       bo_c;
  logic [WAIT_W-1:0]   bo_wait;
  logic [FACTOR_W-1:0] hi_eff;
  logic [FACTOR_W-1:0] lo_eff;
  logic [13:0]         lo_mult;
  logic [RTT_W-1:0]    exp_eff;
  logic [MAXDIV_W-1:0] maxd;
  logic [DIV_W-1:0]    maxv;
  logic [MINDEG_W-1:0] mind;
  logic [29:0]         m_scaled;
  logic                above;
  logic                below;
  logic [DEG_W-1:0]    deg_inc;
  logic [DIV_W:0]      dbl;
  logic [DIV_W-1:0]    half;

  // backoff wait
  assign base_eff = (base == '0) ? BASE_W'(1) : base;
  assign cap_eff  = (cap < WAIT_W'(base_eff)) ? WAIT_W'(base_eff) : cap;
  assign shift    = (streak < SHIFT_LIM) ? streak : SHIFT_LIM;
  assign bo       = SW'(base_eff) << shift;
  assign bo_c     = CW'(bo);
  assign bo_wait  = (bo_c > CW'(cap_eff)) ? cap_eff : bo_c[WAIT_W-1:0];

  // thresholds
  assign hi_eff  = (high_f < FACTOR_ONE) ? HIGH_DEFAULT : high_f;
  assign lo_eff  = (low_f < FACTOR_ONE) ? LOW_DEFAULT : low_f;
  assign lo_mult = (lo_eff >= hi_eff) ? (14'(hi_eff) * 14'd3) : {lo_eff, 2'b00};
  assign exp_eff = (expected == '0) ? RTT_W'(1) : expected;

  assign maxd = (maxdiv == '0) ? MAXDIV_W'(1) :
                ((maxdiv > MAXDIV_LIMIT) ? MAXDIV_LIMIT : maxdiv);
  assign maxv = {maxd, 6'b000000};
  assign mind = (mindeg == '0) ? MINDEG_W'(1) : mindeg;

  assign m_scaled = {4'b0000, median, 10'b0};
  assign above    = m_scaled > {p_hi, 2'b00};
  assign below    = m_scaled < p_lo;
  assign deg_inc  = (degraded < DEGRADED_LIMIT) ? degraded + 1'b1 : degraded;
  assign dbl      = {divisor, 1'b0};
  assign half     = divisor >> 1;

  always_comb begin
    wait_next     = '0;
    streak_next   = streak;
    degraded_next = degraded;
    divisor_next  = divisor;
    bflag_next    = 1'b0;
    sflag_next    = sflag;
    if (limited) begin
      wait_next = (retry != '0) ? ((retry < cap_eff) ? retry : cap_eff) : bo_wait;
      if (streak < STREAK_LIMIT) begin
        streak_next = streak + 1'b1;
      end
      bflag_next = 1'b1;
    end else begin
      streak_next = '0;
      if (median != '0) begin
        if (above) begin
          degraded_next = deg_inc;
          if (deg_inc >= DEG_W'(mind) && divisor < maxv) begin
            divisor_next  = (dbl < {1'b0, maxv}) ? dbl[DIV_W-1:0] : maxv;
            sflag_next    = 1'b1;
            degraded_next = '0;
          end
        end else if (below) begin
          degraded_next = '0;
          if (divisor > DIV_ONE) begin
            divisor_next = (half > DIV_ONE) ? half : DIV_ONE;
            if (half <= DIV_ONE) begin
              sflag_next = 1'b0;
            end
          end
        end else if (degraded != '0) begin
          degraded_next = degraded - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      streak      <= '0;
      degraded    <= '0;
      divisor     <= DIV_ONE;
      sflag       <= 1'b0;
      session_min <= RTT_W'(1);
    end else begin
      if (ctl.seed) begin
        session_min <= exp_eff;
      end else if (ctl.accept && rtt != '0 && rtt < session_min) begin
        session_min <= rtt;
      end
      if (ctl.decide) begin
        streak   <= streak_next;
        degraded <= degraded_next;
        divisor  <= divisor_next;
        sflag    <= sflag_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.mul) begin
      p_hi <= 28'(hi_eff) * 28'(session_min);
      p_lo <= 30'(lo_mult) * 30'(session_min);
    end
  end

endmodule

[rtl/core/rtt_rate_governor.sv]
// RTT rate governor. Each report transfer (rtt_ms, limit_hit, retry_hint_ms)
// gives exactly one result transfer. The last WINDOW_DEPTH RTTs sit in a row of
// cells; the upper median is found by a rank count: a copy of the samples
// rotates once round the row while every cell counts the samples below and not
// above its own, then a token walks the row to bring out the matching sample. A
// load state comes first, then the two threshold products are formed and a
// decision state follows. The next report can be taken in the same cycle as the
// result becomes valid, one report at a time. A finished result waits in the
// output register while the next report is taken; a second result stalls the
// decision state until the output register is free. Rate-limited reports give a
// capped exponential backoff or the capped retry-after hint; other reports run
// the divisor hysteresis. Configuration writes take effect at once and are
// meant for idle periods.
module rtt_rate_governor #(
  parameter int WINDOW_DEPTH = rrg_pkg::DEF_WINDOW_DEPTH,
  parameter int MAX_SHIFT    = rrg_pkg::DEF_MAX_SHIFT
) (
  input  logic                             clk,
  input  logic                             rst,
  // report channel
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [rrg_pkg::RTT_W-1:0]        rtt_ms,
  input  logic                             limit_hit,
  input  logic [rrg_pkg::WAIT_W-1:0]       retry_hint_ms,
  // result channel
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [rrg_pkg::WAIT_W-1:0]       backoff_wait_ms,
  output logic [rrg_pkg::RTT_W-1:0]        median_rtt,
  output logic [rrg_pkg::RTT_W-1:0]        reference_rtt,
  output logic [rrg_pkg::DIV_W-1:0]        divisor,
  output logic                             backoff_active,
  output logic                             self_limited,
  // configuration
  input  logic                             cfg_we,
  input  logic [rrg_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rrg_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import rrg_pkg::*;

  localparam int CNT_W  = $clog2(WINDOW_DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(WINDOW_DEPTH);
  localparam logic [CNT_W-1:0] LAST_C  = CNT_W'(WINDOW_DEPTH - 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_LOAD  = 3'd1;
  localparam logic [2:0] S_COUNT = 3'd2;
  localparam logic [2:0] S_SCAN  = 3'd3;
  localparam logic [2:0] S_MUL   = 3'd4;
  localparam logic [2:0] S_DEC   = 3'd5;

  logic [2:0]       state;
  logic [2:0]       state_next;
  logic [CNT_W-1:0] step;
  logic [CNT_W-1:0] fill;
  logic             lim_q;
  logic [WAIT_W-1:0] retry_q;
  logic [RTT_W-1:0] median;
  logic             accept;
  logic             emit;

  // configuration registers; expected RTT only seeds the reference, so it is
  // taken straight from the write data
  logic [BASE_W-1:0]   reg_base;
  logic [WAIT_W-1:0]   reg_cap;
  logic [MAXDIV_W-1:0] reg_maxdiv;
  logic [FACTOR_W-1:0] reg_high;
  logic [FACTOR_W-1:0] reg_low;
  logic [MINDEG_W-1:0] reg_mindeg;

  chain_ctl_t  cctl;
  policy_ctl_t pctl;

  logic [WAIT_W-1:0] wait_next;
  logic [RTT_W-1:0]  session_min;
  logic [DIV_W-1:0]  divisor_next;
  logic              bflag_next;
  logic              sflag_next;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  // result leaves the decision state only when the output register is free
  assign emit     = (state == S_DEC) && (!out_valid || out_ready);

  always_comb begin
    cctl.shift = accept;
    cctl.load  = (state == S_LOAD);
    cctl.count = (state == S_COUNT);
    cctl.scan  = (state == S_SCAN);
    pctl.accept = accept;
    pctl.mul    = (state == S_MUL);
    pctl.decide = emit;
    // expected RTT reseeds the reference only before the first report
    pctl.seed   = cfg_we && (cfg_index == REG_EXPECTED) && (fill == '0);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (accept) state_next = S_LOAD;
      S_LOAD:  state_next = S_COUNT;
      S_COUNT: if (step == LAST_C) state_next = S_SCAN;
      S_SCAN:  if (step == LAST_C) state_next = S_MUL;
      S_MUL:   state_next = S_DEC;
      S_DEC:   if (emit) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      step      <= '0;
      fill      <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if ((state == S_COUNT || state == S_SCAN) && step != LAST_C) begin
        step <= step + 1'b1;
      end else begin
        step <= '0;
      end
      if (accept && fill != DEPTH_C) begin
        fill <= fill + 1'b1;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      lim_q   <= limit_hit;
      retry_q <= retry_hint_ms;
    end
    if (emit) begin
      backoff_wait_ms <= wait_next;
      median_rtt      <= median;
      reference_rtt   <= session_min;
      divisor         <= divisor_next;
      backoff_active  <= bflag_next;
      self_limited    <= sflag_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      reg_base     <= BASE_W'(1);
      reg_cap      <= WAIT_W'(1);
      reg_maxdiv   <= MAXDIV_W'(1);
      reg_high     <= HIGH_DEFAULT;
      reg_low      <= LOW_DEFAULT;
      reg_mindeg   <= MINDEG_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BASE:     reg_base     <= cfg_data[BASE_W-1:0];
        REG_CAP:      reg_cap      <= cfg_data[WAIT_W-1:0];
        REG_MAXDIV:   reg_maxdiv   <= cfg_data[MAXDIV_W-1:0];
        REG_EXPECTED: ;
        REG_HIGH:     reg_high     <= cfg_data[FACTOR_W-1:0];
        REG_LOW:      reg_low      <= cfg_data[FACTOR_W-1:0];
        REG_MINDEG:   reg_mindeg   <= cfg_data[MINDEG_W-1:0];
        default: ;
      endcase
    end
  end

  rrg_chain #(
    .WINDOW_DEPTH (WINDOW_DEPTH),
    .CNT_W        (CNT_W)
  ) u_chain (
    .clk     (clk),
    .ctl     (cctl),
    .fill    (fill),
    .new_rtt (rtt_ms),
    .median  (median)
  );

  rrg_policy #(
    .MAX_SHIFT (MAX_SHIFT)
  ) u_policy (
    .clk          (clk),
    .rst          (rst),
    .ctl          (pctl),
    .rtt          (rtt_ms),
    .limited      (lim_q),
    .retry        (retry_q),
    .median       (median),
    .base         (reg_base),
    .cap          (reg_cap),
    .maxdiv       (reg_maxdiv),
    .expected     (cfg_data[RTT_W-1:0]),
    .high_f       (reg_high),
    .low_f        (reg_low),
    .mindeg       (reg_mindeg),
    .wait_next    (wait_next),
    .session_min  (session_min),
    .divisor_next (divisor_next),
    .bflag_next   (bflag_next),
    .sflag_next   (sflag_next)
  );

endmodule

[tb/tb_rtt_rate_governor.sv]
`timescale 1ns / 1ps

module tb_rtt_rate_governor;
  import rrg_pkg::*;

  localparam int WIN       = 64;
  localparam int SHIFT_MAX = 20;
  localparam int LATENCY   = 2 * WIN + 4;
  localparam int N_RANDOM  = 750;
  localparam longint CYCLE_LIMIT = 3000000;
  localparam logic [CFG_IDX_W-1:0] REG_NONE = 3'd7;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [RTT_W-1:0]      rtt_ms = '0;
  logic                  limit_hit = 1'b0;
  logic [WAIT_W-1:0]     retry_hint_ms = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [WAIT_W-1:0]     backoff_wait_ms;
  logic [RTT_W-1:0]      median_rtt;
  logic [RTT_W-1:0]      reference_rtt;
  logic [DIV_W-1:0]      divisor;
  logic                  backoff_active;
  logic                  self_limited;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  always #5 clk = ~clk;

  rtt_rate_governor u_dut (
    .clk, .rst,
    .in_valid, .in_ready, .rtt_ms, .limit_hit, .retry_hint_ms,
    .out_valid, .out_ready, .backoff_wait_ms, .median_rtt, .reference_rtt,
    .divisor, .backoff_active, .self_limited,
    .cfg_we, .cfg_index, .cfg_data
  );

  // one governor verdict
  typedef struct packed {
    logic [WAIT_W-1:0] wait_ms;
    logic [RTT_W-1:0]  med;
    logic [RTT_W-1:0]  ref_rtt;
    logic [DIV_W-1:0]  div;
    logic              in_backoff;
    logic              throttled;
  } verdict_t;

  verdict_t verdict_q[$];
  int       errors    = 0;
  int       checked   = 0;
  int       n_limited = 0;
  int       n_doubled = 0;
  longint   cycles    = 0;
  bit       long_hold = 1'b0;  // receiver stall request for the fill-up phase

  // ---------------------------------------------------------------------------
  // Shadow of the governor: registers and state, in the block's own widths
  // ---------------------------------------------------------------------------
  logic [BASE_W-1:0]   g_base;
  logic [WAIT_W-1:0]   g_cap;
  logic [MAXDIV_W-1:0] g_maxdiv;
  logic [RTT_W-1:0]    g_expected;
  logic [FACTOR_W-1:0] g_high, g_low;
  logic [MINDEG_W-1:0] g_mindeg;
  logic [RTT_W-1:0]    g_ring[WIN];
  int unsigned         g_fill, g_head;
  logic [RTT_W-1:0]    g_min;
  int unsigned         g_streak, g_degraded;
  logic [DIV_W-1:0]    g_div;
  logic                g_backoff, g_throttled;

  function automatic logic [RTT_W-1:0] seed_of(logic [RTT_W-1:0] e);
    return (e == 0) ? RTT_W'(1) : e;
  endfunction

  function automatic void governor_reset();
    g_base = 1; g_cap = 1; g_maxdiv = 1; g_expected = 1;
    g_high = HIGH_DEFAULT; g_low = LOW_DEFAULT; g_mindeg = 1;
    g_fill = 0; g_head = 0; g_min = 1; g_streak = 0; g_degraded = 0;
    g_div = DIV_ONE; g_backoff = 0; g_throttled = 0;
  endfunction

  function automatic void governor_write(logic [CFG_IDX_W-1:0] idx,
                                         logic [CFG_DATA_W-1:0] val);
    case (idx)
      REG_BASE:     g_base = val[BASE_W-1:0];
      REG_CAP:      g_cap = val[WAIT_W-1:0];
      REG_MAXDIV:   g_maxdiv = val[MAXDIV_W-1:0];
      REG_EXPECTED: begin
        g_expected = val[RTT_W-1:0];
        if (g_fill == 0) g_min = seed_of(g_expected);
      end
      REG_HIGH:     g_high = val[FACTOR_W-1:0];
      REG_LOW:      g_low = val[FACTOR_W-1:0];
      REG_MINDEG:   g_mindeg = val[MINDEG_W-1:0];
      default: ;
    endcase
  endfunction

  // upper median: element of rank fill/2 in sorted order
  function automatic logic [RTT_W-1:0] window_median();
    logic [RTT_W-1:0] s[$];
    for (int i = 0; i < g_fill; i++) s.insert(s.size(), g_ring[i]);
    s.sort();
    return s[g_fill / 2];
  endfunction

  function automatic verdict_t governor_step(logic [RTT_W-1:0] rtt, logic lim,
                                             logic [WAIT_W-1:0] retry);
    verdict_t v;
    longint   base, cap, b, hi, lo, m, hi_t, lo_t, maxv, mind, d;
    int       sh;
    logic [RTT_W-1:0] med;
    g_ring[g_head] = rtt;
    g_head = (g_head + 1) % WIN;
    if (g_fill < WIN) g_fill++;
    med = window_median();
    if (rtt != 0 && rtt < g_min) g_min = rtt;
    b = 0;
    if (lim) begin
      base = (g_base == 0) ? 1 : g_base;
      cap  = (g_cap < base) ? base : g_cap;
      sh   = (g_streak < SHIFT_MAX) ? g_streak : SHIFT_MAX;
      b    = base << sh;
      if (b > cap) b = cap;
      if (retry != 0) b = (retry < cap) ? retry : cap;
      if (g_streak < STREAK_LIMIT) g_streak++;
      g_backoff = 1;
    end else begin
      g_streak = 0;
      g_backoff = 0;
      if (med != 0) begin
        hi   = (g_high < FACTOR_ONE) ? HIGH_DEFAULT : g_high;
        lo   = (g_low < FACTOR_ONE) ? LOW_DEFAULT : g_low;
        m    = longint'(med) * 1024;
        hi_t = hi * 4 * g_min;
        lo_t = (lo >= hi) ? hi * 3 * g_min : lo * 4 * g_min;
        maxv = ((g_maxdiv == 0) ? 1 : (g_maxdiv > MAXDIV_LIMIT ? 64 : g_maxdiv)) * 64;
        mind = (g_mindeg == 0) ? 1 : g_mindeg;
        if (m > hi_t) begin
          if (g_degraded < DEGRADED_LIMIT) g_degraded++;
          if (g_degraded >= mind && g_div < maxv) begin
            d = g_div * 2;
            g_div = DIV_W'((d < maxv) ? d : maxv);
            g_throttled = 1;
            g_degraded = 0;
            n_doubled++;
          end
        end else if (m < lo_t) begin
          g_degraded = 0;
          if (g_div > DIV_ONE) begin
            d = g_div / 2;
            g_div = DIV_W'((d > DIV_ONE) ? d : DIV_ONE);
            if (g_div <= DIV_ONE) g_throttled = 0;
          end
        end else if (g_degraded > 0) begin
          g_degraded--;
        end
      end
    end
    v.wait_ms = WAIT_W'(b); v.med = med; v.ref_rtt = g_min; v.div = g_div;
    v.in_backoff = g_backoff; v.throttled = g_throttled;
    return v;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender and configuration helpers
  // ---------------------------------------------------------------------------
  task automatic idle_gap();
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) n = 0;
    repeat (n) @(posedge clk);
  endtask

  // offer one report and queue the predicted verdict; returns only after the cycle
  // that follows the transfer, so that valid is low for at least that cycle
  task automatic send_report(input logic [RTT_W-1:0] rtt, input logic lim,
                             input logic [WAIT_W-1:0] retry, input bit gap);
    verdict_t v;
    if (gap) idle_gap();
    in_valid       <= 1'b1;
    rtt_ms         <= rtt;
    limit_hit      <= lim;
    retry_hint_ms  <= retry;
    do @(posedge clk); while (!in_ready);
    in_valid <= 1'b0;
    v = governor_step(rtt, lim, retry);
    verdict_q.insert(verdict_q.size(), v);
    if (lim) n_limited++;
    @(posedge clk);
  endtask

  // wait for idle, then let the block's own pipeline drain
  task automatic settle();
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    governor_write(idx, val);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: random stalls, plus one long hold-off on request
  // ---------------------------------------------------------------------------
  initial begin
    int n;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (long_hold) begin
        out_ready <= 1'b0;
        repeat (3 * LATENCY) @(posedge clk);
        long_hold = 1'b0;
      end
      n = $urandom_range(0, 7);
      if (n == 0)      out_ready <= 1'b0;
      else if (n == 1) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(20, 200)) @(posedge clk);
      end else out_ready <= 1'b1;
    end
  end

  // result checker
  always @(posedge clk) begin
    verdict_t e;
    if (!rst && out_valid && out_ready) begin
      if (verdict_q.size() == 0) begin
        $display("%0t: unexpected result transfer", $time);
        errors++;
      end else begin
        e = verdict_q[0];
        verdict_q.delete(0);
        checked++;
        if (backoff_wait_ms !== e.wait_ms) begin
          $display("%0t: backoff_wait_ms exp %0d got %0d", $time, e.wait_ms, backoff_wait_ms);
          errors++;
        end
        if (median_rtt !== e.med) begin
          $display("%0t: median_rtt exp %0d got %0d", $time, e.med, median_rtt);
          errors++;
        end
        if (reference_rtt !== e.ref_rtt) begin
          $display("%0t: reference_rtt exp %0d got %0d", $time, e.ref_rtt, reference_rtt);
          errors++;
        end
        if (divisor !== e.div) begin
          $display("%0t: divisor exp %0d got %0d", $time, e.div, divisor);
          errors++;
        end
        if (backoff_active !== e.in_backoff) begin
          $display("%0t: backoff_active exp %0b got %0b", $time, e.in_backoff, backoff_active);
          errors++;
        end
        if (self_limited !== e.throttled) begin
          $display("%0t: self_limited exp %0b got %0b", $time, e.throttled, self_limited);
          errors++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d transfers outstanding", $time, verdict_q.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Directed table. chk marks rows whose verdict is typed in; others rely on
  // the shadow model alone.
  // ---------------------------------------------------------------------------
  typedef struct {
    logic [RTT_W-1:0]  rtt;
    logic              lim;
    logic [WAIT_W-1:0] retry;
    bit                chk;
    verdict_t          want;
  } row_t;

  row_t rows[] = '{
    // first report after reset: window of one, seed 1, zero rtt holds minimum
    '{16'd0,     1'b0, 20'd0,       1'b1, '{20'd0, 16'd0, 16'd1, 13'd64, 1'b0, 1'b0}},
    '{16'hFFFF,  1'b0, 20'd0,       1'b0, '0},
    '{16'd1,     1'b0, 20'd0,       1'b0, '0},
    // backoff with reset registers: base 1, cap 1
    '{16'd5,     1'b1, 20'd0,       1'b0, '0},
    '{16'd5,     1'b1, 20'hFFFFF,   1'b0, '0},
    '{16'd7,     1'b1, 20'd0,       1'b0, '0},
    '{16'd3,     1'b0, 20'd12345,   1'b0, '0},
    '{16'd0,     1'b0, 20'd0,       1'b0, '0},
    '{16'd0,     1'b0, 20'd0,       1'b0, '0},
    '{16'h8000,  1'b1, 20'd1,       1'b0, '0},
    '{16'h7FFF,  1'b0, 20'h55555,   1'b0, '0},
    '{16'd2,     1'b0, 20'hAAAAA,   1'b0, '0}
  };

  // run of same-class reports for the governor phases
  task automatic burst(input int n, input int lo, input int hi, input int lim_pct);
    logic lim;
    logic [WAIT_W-1:0] r;
    for (int i = 0; i < n; i++) begin
      lim = ($urandom_range(0, 99) < lim_pct);
      r = ($urandom_range(0, 2) == 0) ? $urandom() : 0;
      if ($urandom_range(0, 15) == 0) r = 20'hFFFFF;
      send_report($urandom_range(lo, hi), lim, r, 1'b1);
    end
  endtask

  initial begin
    int sent = 0;
    governor_reset();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reseed before any report: expected RTT written while window empty
    write_reg(REG_EXPECTED, 20'd0);
    write_reg(REG_EXPECTED, 20'd1);
    foreach (rows[i]) begin
      send_report(rows[i].rtt, rows[i].lim, rows[i].retry, 1'b1);
      if (rows[i].chk && verdict_q[$] !== rows[i].want) begin
        $display("%0t: table row %0d exp %h model %h", $time, i, rows[i].want, verdict_q[$]);
        errors++;
      end
    end
    settle();

    // real backoff: small base, large cap, long streak to saturate shift
    write_reg(REG_BASE, 20'd3);
    write_reg(REG_CAP, 20'hFFFFF);
    for (int i = 0; i < 36; i++) send_report($urandom(), 1'b1, 20'd0, i > 30);
    send_report(16'd10, 1'b0, 20'd0, 1'b1);
    settle();
    // extremes of base and cap; cap below base; zero values
    write_reg(REG_BASE, 20'hFFFF);
    write_reg(REG_CAP, 20'd1);
    burst(4, 0, 65535, 100);
    settle();
    write_reg(REG_BASE, 20'd0);
    write_reg(REG_CAP, 20'd0);
    burst(3, 0, 65535, 100);
    settle();

    // governor phases, each a batch of settings
    for (int phase = 0; phase < 8; phase++) begin
      write_reg(REG_BASE, $urandom_range(0, 2000));
      write_reg(REG_CAP, (phase == 3) ? 20'hFFFFF : $urandom_range(0, 200000));
      write_reg(REG_MAXDIV, (phase == 0) ? 20'd64 : (phase == 1) ? 20'd127 :
                            (phase == 2) ? 20'd0 : $urandom_range(1, 80));
      write_reg(REG_EXPECTED, (phase == 4) ? 20'hFFFF : $urandom_range(0, 300));
      write_reg(REG_HIGH, (phase == 5) ? 20'hFFF : (phase == 6) ? 20'd100 :
                          $urandom_range(256, 700));
      write_reg(REG_LOW, (phase == 5) ? 20'hFFF : (phase == 7) ? 20'd0 :
                         (phase == 2) ? 20'd900 : $urandom_range(256, 600));
      write_reg(REG_MINDEG, (phase == 1) ? 20'h3FF : (phase == 2) ? 20'd0 :
                            $urandom_range(1, 4));
      write_reg(REG_NONE, $urandom());  // beyond the list: ignored
      if (phase == 2) long_hold = 1'b1;  // fill-up while the sender keeps going
      for (int k = 0; k < 2 && sent < N_RANDOM; k++) begin
        // low baseline, then a spike to degrade, then recovery
        burst(8, 1, 40, 5);
        burst(16, 300, 65535, 5);
        burst(20, 1, 30, 10);
        if ($urandom_range(0, 1)) burst(4, 0, 65535, 40);
        sent += 48;
      end
      settle();
    end

    $display("reports checked: %0d, rate-limited: %0d, divisor doublings: %0d",
             checked, n_limited, n_doubled);
    $display("covered reset values, backoff saturation, clamped registers and stalls");
    if (errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule

[rtt_rate_governor.f]
rtl/core/rrg_pkg.sv
rtl/core/rrg_cell.sv
rtl/core/rrg_chain.sv
rtl/core/rrg_policy.sv
rtl/core/rtt_rate_governor.sv
tb/tb_rtt_rate_governor.sv
